// ===== hw/rtl/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// Proportional text layout package
// Shared constants, register indexes, payload structs and the scale helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

   // Defaults for the top-level parameters
   localparam int GLYPH_ENTRIES_DEF = 256;
   localparam int PEN_BITS_DEF      = 16;

   // Result queue: records of one item each
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Item commands
   localparam logic CMD_METRICS = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // Result kinds
   localparam logic KIND_GLYPH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_CELL_W   = 3'd0;
   localparam logic [2:0] CSR_CELL_H   = 3'd1;
   localparam logic [2:0] CSR_LAYOUT   = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_X = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd4;
   localparam logic [2:0] CSR_SCALE    = 3'd5;

   // Atlas layouts; the unused code behaves as the grid
   localparam logic [1:0] LAYOUT_GRID   = 2'd0;
   localparam logic [1:0] LAYOUT_COLUMN = 2'd1;
   localparam logic [1:0] LAYOUT_ROW    = 2'd2;

   // Configuration reset values
   localparam logic [7:0]  CELL_W_RST = 8'd16;
   localparam logic [7:0]  CELL_H_RST = 8'd16;
   localparam logic [11:0] SCALE_RST  = 12'd256;

   // UTF-8 byte classes and special characters
   localparam logic [7:0] UTF_LEAD_MASK = 8'hE0;
   localparam logic [7:0] UTF_LEAD      = 8'hC0;
   localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
   localparam logic [7:0] UTF_CONT      = 8'h80;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   typedef struct packed {
      logic [7:0]         cell_w;
      logic [7:0]         cell_h;
      logic [1:0]         layout;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [11:0]        scale;
   } ptl_cfg_type;

   typedef struct packed {
      logic [7:0] left;
      logic [7:0] draw_width;
      logic [7:0] advance;
   } ptl_metrics_type;

   // One decoded code point: newline or a glyph table index
   typedef struct packed {
      logic       valid;
      logic       newline;
      logic [7:0] idx;
   } ptl_code_type;

   // A text item after decode: up to two codes, in order
   typedef struct packed {
      logic                    valid;
      logic                    eos;
      ptl_code_type [1:0]      code;
   } ptl_item_type;

   // A code after table lookup and scaling
   typedef struct packed {
      logic        valid;
      logic        newline;
      logic        draw;
      logic [15:0] src_x;
      logic [15:0] src_y;
      logic [7:0]  src_w;
      logic [11:0] dst_w;
      logic [11:0] adv;
   } ptl_glyph_type;

   typedef struct packed {
      logic [15:0] src_x;
      logic [15:0] src_y;
      logic [7:0]  src_w;
      logic [15:0] dst_x;
      logic [15:0] dst_y;
      logic [11:0] dst_w;
   } ptl_rect_type;

   // All results of one item
   typedef struct packed {
      logic [1:0]         glyph_valid;
      logic               sum_valid;
      ptl_rect_type [1:0] rect;
      logic [7:0]         src_h;
      logic [11:0]        dst_h;
      logic [15:0]        measured;
   } ptl_rec_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] src_x;
      logic [15:0] src_y;
      logic [7:0]  src_w;
      logic [7:0]  src_h;
      logic [15:0] dst_x;
      logic [15:0] dst_y;
      logic [11:0] dst_w;
      logic [11:0] dst_h;
      logic [15:0] measured;
      logic        last;
   } ptl_rsp_type;

   // floor(value * scale / 256), at least 1
   function automatic logic [11:0] ptl_scale(input logic [7:0] value,
                                             input logic [11:0] scale);
      logic [19:0] prod;
      prod = {12'd0, value} * {8'd0, scale};
      return (prod[19:8] == 12'd0) ? 12'd1 : prod[19:8];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptl_glyph_mem.sv =====
// ----------------------------------------------------------------------------
// Glyph metrics memory
// One write port and two registered read ports over the glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_glyph_mem #(
   parameter int ENTRIES = 256
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire [$clog2(ENTRIES)-1:0]   wr_addr,
   input  ptl_pkg::ptl_metrics_type    wr_data,
   input  wire [$clog2(ENTRIES)-1:0]   rd_addr0,
   input  wire [$clog2(ENTRIES)-1:0]   rd_addr1,
   output ptl_pkg::ptl_metrics_type    rd_data0,
   output ptl_pkg::ptl_metrics_type    rd_data1
);
   import ptl_pkg::*;

   ptl_metrics_type mem_ff [ENTRIES];
   ptl_metrics_type rd_data0_ff;
   ptl_metrics_type rd_data1_ff;

   // Write one entry and read two, with registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptl_decode.sv =====
// ----------------------------------------------------------------------------
// Text byte decoder
// Pairs UTF-8 lead and continuation bytes and issues up to two glyph codes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_decode (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire [7:0]              text_byte,
   input  wire                    end_of_string,
   output logic [7:0]             rd_idx0,
   output logic [7:0]             rd_idx1,
   output ptl_pkg::ptl_item_type  item
);
   import ptl_pkg::*;

   logic         pend_ff, pend_in;
   logic [7:0]   lead_ff, lead_in;
   ptl_item_type item_ff, item_in;
   logic         is_cont, is_lead;

   function automatic ptl_code_type make_code(input logic [10:0] cp);
      ptl_code_type c;
      c.valid   = 1'b1;
      c.newline = (cp == {3'd0, CHAR_NEWLINE});
      c.idx     = (cp > 11'd255) ? CHAR_QUESTION : cp[7:0];
      return c;
   endfunction

   // Classify the byte against the held lead byte
   always_comb begin
      is_cont = ((text_byte & UTF_CONT_MASK) == UTF_CONT);
      is_lead = ((text_byte & UTF_LEAD_MASK) == UTF_LEAD) && !end_of_string;
      item_in       = '0;
      item_in.valid = accept;
      item_in.eos   = end_of_string;
      pend_in       = pend_ff;
      lead_in       = lead_ff;
      if (pend_ff && is_cont) begin
         item_in.code[0] = make_code({lead_ff[4:0], text_byte[5:0]});
         pend_in         = 1'b0;
      end else begin
         if (pend_ff) begin
            item_in.code[0] = make_code({3'd0, lead_ff});
            if (!is_lead) begin
               item_in.code[1] = make_code({3'd0, text_byte});
            end
         end else if (!is_lead) begin
            item_in.code[0] = make_code({3'd0, text_byte});
         end
         pend_in = is_lead;
         if (is_lead) begin
            lead_in = text_byte;
         end
      end
   end

   // Look up both codes right away
   assign rd_idx0 = item_in.code[0].idx;
   assign rd_idx1 = item_in.code[1].idx;

   // Hold the lead byte across items
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         lead_ff       <= 8'd0;
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= accept;
         if (accept) begin
            pend_ff <= pend_in;
            lead_ff <= lead_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.eos  <= item_in.eos;
         item_ff.code <= item_in.code;
      end
   end

   assign item = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptl_layout.sv =====
// ----------------------------------------------------------------------------
// Layout pipeline
// Scales looked-up metrics, walks the pen and builds the results of an item.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_layout #(
   parameter int PEN_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  ptl_pkg::ptl_cfg_type             cfg,
   input  ptl_pkg::ptl_item_type            item,
   input  ptl_pkg::ptl_metrics_type [1:0]   rd_data,
   output logic [1:0]                       inflight,
   output logic                             push,
   output ptl_pkg::ptl_rec_type             push_rec
);
   import ptl_pkg::*;

   localparam int SUM_W = ((PEN_BITS > 16) ? PEN_BITS : 16) + 2;
   localparam logic signed [SUM_W-1:0] DST_HI = SUM_W'(32'sd32767);
   localparam logic signed [SUM_W-1:0] DST_LO = SUM_W'(-32'sd32768);

   ptl_glyph_type [1:0]  glyph;
   ptl_glyph_type [1:0]  glyph_ff;
   logic                 s2_valid_ff;
   logic                 eos_ff;
   logic [11:0]          scaled_h_ff;
   logic [PEN_BITS-1:0]  pen_x_ff, pen_x_in;
   logic [PEN_BITS-1:0]  pen_y_ff, pen_y_in;
   logic [PEN_BITS-1:0]  widest_ff, widest_in;
   ptl_rec_type          rec;

   function automatic logic [PEN_BITS-1:0] pen_add(input logic [PEN_BITS-1:0] base,
                                                   input logic [11:0] step);
      logic [PEN_BITS:0] sum;
      sum = {1'b0, base} + {{(PEN_BITS-11){1'b0}}, step};
      return sum[PEN_BITS] ? {PEN_BITS{1'b1}} : sum[PEN_BITS-1:0];
   endfunction

   function automatic logic [15:0] dst_sat(input logic [15:0] origin,
                                           input logic [PEN_BITS-1:0] off);
      logic signed [SUM_W-1:0] sum;
      sum = $signed({{(SUM_W-16){origin[15]}}, origin})
          + $signed({{(SUM_W-PEN_BITS){1'b0}}, off});
      if (sum > DST_HI) begin
         return 16'h7FFF;
      end else if (sum < DST_LO) begin
         return 16'h8000;
      end
      return sum[15:0];
   endfunction

   function automatic logic [15:0] width_sat(input logic [PEN_BITS-1:0] v);
      logic [PEN_BITS+15:0] wide;
      wide = {16'd0, v};
      return (|wide[PEN_BITS+15:16]) ? 16'hFFFF : wide[15:0];
   endfunction

   // Stage 1: atlas position and scaled sizes of each code
   always_comb begin
      logic [7:0] col;
      logic [7:0] row;
      for (int k = 0; k < 2; k++) begin
         case (cfg.layout)
            LAYOUT_COLUMN: begin
               col = 8'd0;
               row = item.code[k].idx;
            end
            LAYOUT_ROW: begin
               col = item.code[k].idx;
               row = 8'd0;
            end
            default: begin
               col = {4'd0, item.code[k].idx[3:0]};
               row = {4'd0, item.code[k].idx[7:4]};
            end
         endcase
         glyph[k].valid   = item.valid && item.code[k].valid;
         glyph[k].newline = item.code[k].newline;
         glyph[k].draw    = (rd_data[k].draw_width != 8'd0);
         glyph[k].src_x   = ({8'd0, col} * {8'd0, cfg.cell_w}) + {8'd0, rd_data[k].left};
         glyph[k].src_y   = {8'd0, row} * {8'd0, cfg.cell_h};
         glyph[k].src_w   = rd_data[k].draw_width;
         glyph[k].dst_w   = ptl_scale(rd_data[k].draw_width, cfg.scale);
         glyph[k].adv     = ptl_scale(rd_data[k].advance, cfg.scale);
      end
   end

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= item.valid;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph;
      eos_ff      <= item.eos;
      scaled_h_ff <= ptl_scale(cfg.cell_h, cfg.scale);
   end

   // Stage 2: walk the pen over both codes, then close the string
   always_comb begin
      logic [PEN_BITS-1:0] px;
      logic [PEN_BITS-1:0] py;
      logic [PEN_BITS-1:0] wd;
      px  = pen_x_ff;
      py  = pen_y_ff;
      wd  = widest_ff;
      rec = '0;
      for (int k = 0; k < 2; k++) begin
         if (glyph_ff[k].valid) begin
            if (glyph_ff[k].newline) begin
               if (px > wd) begin
                  wd = px;
               end
               px = '0;
               py = pen_add(py, scaled_h_ff);
            end else begin
               rec.glyph_valid[k]  = glyph_ff[k].draw;
               rec.rect[k].src_x   = glyph_ff[k].src_x;
               rec.rect[k].src_y   = glyph_ff[k].src_y;
               rec.rect[k].src_w   = glyph_ff[k].src_w;
               rec.rect[k].dst_x   = dst_sat(cfg.origin_x, px);
               rec.rect[k].dst_y   = dst_sat(cfg.origin_y, py);
               rec.rect[k].dst_w   = glyph_ff[k].dst_w;
               px = pen_add(px, glyph_ff[k].adv);
            end
         end
      end
      rec.src_h     = cfg.cell_h;
      rec.dst_h     = scaled_h_ff;
      rec.sum_valid = eos_ff;
      rec.measured  = width_sat((px > wd) ? px : wd);
      if (eos_ff) begin
         pen_x_in  = '0;
         pen_y_in  = '0;
         widest_in = '0;
      end else begin
         pen_x_in  = px;
         pen_y_in  = py;
         widest_in = wd;
      end
   end

   // Hold the pen between items, clear at reset and at the end of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         widest_ff <= '0;
      end else if (s2_valid_ff) begin
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         widest_ff <= widest_in;
      end
   end

   assign push     = s2_valid_ff && ((|rec.glyph_valid) || rec.sum_valid);
   assign push_rec = rec;
   assign inflight = {1'b0, item.valid} + {1'b0, s2_valid_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/ptl_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Holds one record per item that has results and hands them out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_rsp_queue (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   input  ptl_pkg::ptl_rec_type               push_rec,
   input  wire                                rsp_ready,
   output logic                               rsp_valid,
   output ptl_pkg::ptl_rsp_type               rsp,
   output logic [ptl_pkg::RSP_CNT_W-1:0]      count
);
   import ptl_pkg::*;

   ptl_rec_type           rec_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic [2:0]            done_ff, done_in;
   ptl_rec_type           head;
   logic [2:0]            avail;
   logic [2:0]            sel;
   logic                  last;
   logic                  step;
   logic                  pop;
   ptl_rect_type          rect;

   // Pick the first result of the head record not yet sent
   always_comb begin
      head  = rec_ff[rd_ptr_ff];
      avail = {head.sum_valid, head.glyph_valid} & ~done_ff;
      sel   = avail & (~avail + 3'd1);
      last  = ((avail & ~sel) == 3'd0);
      rect  = sel[1] ? head.rect[1] : head.rect[0];
      rsp   = '0;
      rsp.last = last;
      if (sel[2]) begin
         rsp.kind     = KIND_SUMMARY;
         rsp.measured = head.measured;
      end else begin
         rsp.kind  = KIND_GLYPH;
         rsp.src_x = rect.src_x;
         rsp.src_y = rect.src_y;
         rsp.src_w = rect.src_w;
         rsp.src_h = head.src_h;
         rsp.dst_x = rect.dst_x;
         rsp.dst_y = rect.dst_y;
         rsp.dst_w = rect.dst_w;
         rsp.dst_h = head.dst_h;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign step      = rsp_valid && rsp_ready;
   assign pop       = step && last;

   // Advance pointers and the sent mask
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      done_in   = done_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         done_in   = 3'd0;
      end else if (step) begin
         done_in = done_ff | sel;
      end
      count_in = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/proportional_text_layout.sv =====
// ----------------------------------------------------------------------------
// Proportional text layout
// Lays out a stream of text bytes with a glyph metrics table (256 entries by default).
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a metrics write (req_cmd = 0) fills one glyph
//   table entry, a text byte (req_cmd = 1) is decoded as UTF-8 and laid out.
//   rsp_* returns glyph rectangles and, on the last byte of a string, the
//   width of the widest line; rsp_last marks the final result of an item.
//   csr_* writes the six configuration registers; csr_ready is always high.
// Path: the first result of a text byte reaches rsp_* through the registered
//   table read, the scaling stage and the pen walk into the result queue.
// Throughput: one item per cycle while req_ready is high. The two-port
//   metrics memory lets a held lead byte and the byte that follows it be
//   looked up in the same cycle. Items with two or three results drain one
//   result per cycle while rsp_ready is high from a four-record queue;
//   req_ready drops once the queue and the two pipeline stages could fill it.
// Reset: clears the pen, the held lead byte, the queue and the registers
//   to their defaults. The glyph table is not cleared: write an entry
//   before any text uses it.
// Stall: a stalled receiver keeps the current result steady; the queue
//   absorbs in-flight items and then req_ready goes low.
// ----------------------------------------------------------------------------
`default_nettype none

module proportional_text_layout #(
   parameter int GLYPH_ENTRIES = ptl_pkg::GLYPH_ENTRIES_DEF,
   parameter int PEN_BITS      = ptl_pkg::PEN_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   // input items
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_cmd,
   input  wire [7:0]          req_glyph_index,
   input  wire [7:0]          req_glyph_left,
   input  wire [7:0]          req_glyph_draw_width,
   input  wire [7:0]          req_glyph_advance,
   input  wire [7:0]          req_text_byte,
   input  wire                req_end_of_string,
   // results
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_kind,
   output logic [15:0]        rsp_src_x,
   output logic [15:0]        rsp_src_y,
   output logic [7:0]         rsp_src_w,
   output logic [7:0]         rsp_src_h,
   output logic signed [15:0] rsp_dst_x,
   output logic signed [15:0] rsp_dst_y,
   output logic [11:0]        rsp_dst_w,
   output logic [11:0]        rsp_dst_h,
   output logic [15:0]        rsp_measured_width,
   output logic               rsp_last,
   // configuration
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [2:0]          csr_index,
   input  wire [15:0]         csr_data
);
   import ptl_pkg::*;

   localparam int ADDR_W = $clog2(GLYPH_ENTRIES);

   ptl_cfg_type               cfg_ff, cfg_in;
   logic                      accept;
   logic                      text_accept;
   logic                      meta_write;
   ptl_metrics_type           wr_data;
   logic [7:0]                rd_idx0;
   logic [7:0]                rd_idx1;
   ptl_metrics_type [1:0]     rd_data;
   ptl_item_type              item;
   logic [1:0]                inflight;
   logic                      push;
   ptl_rec_type               push_rec;
   ptl_rsp_type               rsp;
   logic [RSP_CNT_W-1:0]      q_count;
   logic [RSP_CNT_W:0]        q_need;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CELL_W:   cfg_in.cell_w   = csr_data[7:0];
            CSR_CELL_H:   cfg_in.cell_h   = csr_data[7:0];
            CSR_LAYOUT:   cfg_in.layout   = csr_data[1:0];
            CSR_ORIGIN_X: cfg_in.origin_x = $signed(csr_data);
            CSR_ORIGIN_Y: cfg_in.origin_y = $signed(csr_data);
            CSR_SCALE:    cfg_in.scale    = csr_data[11:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_w   <= CELL_W_RST;
         cfg_ff.cell_h   <= CELL_H_RST;
         cfg_ff.layout   <= LAYOUT_GRID;
         cfg_ff.origin_x <= 16'sd0;
         cfg_ff.origin_y <= 16'sd0;
         cfg_ff.scale    <= SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept while the queue can take every item in flight
   assign q_need      = {1'b0, q_count} + (RSP_CNT_W + 1)'(inflight);
   assign req_ready   = (q_need < (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign accept      = req_valid && req_ready;
   assign text_accept = accept && (req_cmd == CMD_TEXT);
   assign meta_write  = accept && (req_cmd == CMD_METRICS);

   assign wr_data.left       = req_glyph_left;
   assign wr_data.draw_width = req_glyph_draw_width;
   assign wr_data.advance    = req_glyph_advance;

   ptl_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (text_accept),
      .text_byte     (req_text_byte),
      .end_of_string (req_end_of_string),
      .rd_idx0       (rd_idx0),
      .rd_idx1       (rd_idx1),
      .item          (item)
   );

   ptl_glyph_mem #(
      .ENTRIES (GLYPH_ENTRIES)
   ) u_glyph_mem (
      .clock    (clock),
      .wr_en    (meta_write),
      .wr_addr  (req_glyph_index[ADDR_W-1:0]),
      .wr_data  (wr_data),
      .rd_addr0 (rd_idx0[ADDR_W-1:0]),
      .rd_addr1 (rd_idx1[ADDR_W-1:0]),
      .rd_data0 (rd_data[0]),
      .rd_data1 (rd_data[1])
   );

   ptl_layout #(
      .PEN_BITS (PEN_BITS)
   ) u_layout (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .item     (item),
      .rd_data  (rd_data),
      .inflight (inflight),
      .push     (push),
      .push_rec (push_rec)
   );

   ptl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .count     (q_count)
   );

   // Result ports
   assign rsp_kind           = rsp.kind;
   assign rsp_src_x          = rsp.src_x;
   assign rsp_src_y          = rsp.src_y;
   assign rsp_src_w          = rsp.src_w;
   assign rsp_src_h          = rsp.src_h;
   assign rsp_dst_x          = $signed(rsp.dst_x);
   assign rsp_dst_y          = $signed(rsp.dst_y);
   assign rsp_dst_w          = rsp.dst_w;
   assign rsp_dst_h          = rsp.dst_h;
   assign rsp_measured_width = rsp.measured;
   assign rsp_last           = rsp.last;

endmodule

`default_nettype wire

// ===== hw/rtl/ptl_checker.sv =====
// ----------------------------------------------------------------------------
// Layout port checker
// Watches the top-level ports for result ordering and content rules.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                req_cmd,
   input wire [7:0]          req_glyph_index,
   input wire [7:0]          req_glyph_left,
   input wire [7:0]          req_glyph_draw_width,
   input wire [7:0]          req_glyph_advance,
   input wire [7:0]          req_text_byte,
   input wire                req_end_of_string,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire                rsp_kind,
   input wire [15:0]         rsp_src_x,
   input wire [15:0]         rsp_src_y,
   input wire [7:0]          rsp_src_w,
   input wire [7:0]          rsp_src_h,
   input wire signed [15:0]  rsp_dst_x,
   input wire signed [15:0]  rsp_dst_y,
   input wire [11:0]         rsp_dst_w,
   input wire [11:0]         rsp_dst_h,
   input wire [15:0]         rsp_measured_width,
   input wire                rsp_last,
   input wire                csr_valid,
   input wire                csr_ready,
   input wire [2:0]          csr_index,
   input wire [15:0]         csr_data
);
   import ptl_pkg::*;

   // No result comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_dst_x)
                                  && $stable(rsp_src_x) && $stable(rsp_last))
      else $error("stalled result changed");

   // The width summary closes its item and carries no rectangle
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SUMMARY) |->
         rsp_last && (rsp_src_w == 8'd0) && (rsp_dst_w == 12'd0) && (rsp_dst_h == 12'd0))
      else $error("summary result malformed");

   // Drawn glyphs have ink and nonzero scaled sizes
   a_glyph_sizes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_GLYPH) |->
         (rsp_src_w != 8'd0) && (rsp_dst_w != 12'd0) && (rsp_dst_h != 12'd0)
         && (rsp_measured_width == 16'd0))
      else $error("glyph result malformed");

endmodule

bind proportional_text_layout ptl_checker u_ptl_checker (.*);

`default_nettype wire

// ===== sim/tb_proportional_text_layout.sv =====
// ----------------------------------------------------------------------------
// Proportional text layout testbench
// Feeds glyph metrics writes and UTF-8 text strings through the layout block
// across several atlas and scale settings, predicts every glyph rectangle and
// string width summary, and checks each result in order under random stalls.
// ----------------------------------------------------------------------------
module tb_proportional_text_layout;
   timeunit 1ns;
   timeprecision 1ps;

   import ptl_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_PAD    = 8;
   localparam int END_PAD      = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PEN_LIMIT    = 65535;
   localparam int DST_MAX      = 32767;
   localparam int DST_MIN      = -32768;

   // Spare layout code, laid out as the grid
   localparam logic [1:0] LAYOUT_SPARE = 2'd3;

   // Glyphs used to drive the pen into saturation
   localparam logic [7:0] WIDE_GLYPH_A = 8'h4D;
   localparam logic [7:0] WIDE_GLYPH_B = 8'h57;

   typedef struct packed {
      logic       cmd;
      logic [7:0] glyph_index;
      logic [7:0] glyph_left;
      logic [7:0] glyph_draw_width;
      logic [7:0] glyph_advance;
      logic [7:0] text_byte;
      logic       end_of_string;
   } text_item_t;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   text_item_t         req_item  = '0;
   wire                req_ready;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire                rsp_kind;
   wire [15:0]         rsp_src_x;
   wire [15:0]         rsp_src_y;
   wire [7:0]          rsp_src_w;
   wire [7:0]          rsp_src_h;
   wire signed [15:0]  rsp_dst_x;
   wire signed [15:0]  rsp_dst_y;
   wire [11:0]         rsp_dst_w;
   wire [11:0]         rsp_dst_h;
   wire [15:0]         rsp_measured_width;
   wire                rsp_last;
   logic               csr_valid = 1'b0;
   wire                csr_ready;
   logic [2:0]         csr_index = CSR_CELL_W;
   logic [15:0]        csr_data  = '0;

   // Stimulus side
   text_item_t         items_to_send[$];
   bit                 glyph_known[256];
   bit                 gen_held;
   logic [7:0]         gen_lead;

   // Layout predictor state
   logic [7:0]         tbl_left[256];
   logic [7:0]         tbl_draw[256];
   logic [7:0]         tbl_adv[256];
   int unsigned        pen_x, pen_y, widest;
   logic [7:0]         held_lead;
   bit                 held_valid;
   logic [7:0]         cfg_cell_w, cfg_cell_h;
   logic [1:0]         cfg_layout;
   logic signed [15:0] cfg_origin_x, cfg_origin_y;
   logic [11:0]        cfg_scale;
   ptl_rsp_type        item_results[$];
   ptl_rsp_type        layout_results_due[$];

   bit                 req_fire;
   int                 accepted_count;
   int                 err_count;
   int                 cycle_count;

   proportional_text_layout dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_item.cmd),
      .req_glyph_index      (req_item.glyph_index),
      .req_glyph_left       (req_item.glyph_left),
      .req_glyph_draw_width (req_item.glyph_draw_width),
      .req_glyph_advance    (req_item.glyph_advance),
      .req_text_byte        (req_item.text_byte),
      .req_end_of_string    (req_item.end_of_string),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_src_x            (rsp_src_x),
      .rsp_src_y            (rsp_src_y),
      .rsp_src_w            (rsp_src_w),
      .rsp_src_h            (rsp_src_h),
      .rsp_dst_x            (rsp_dst_x),
      .rsp_dst_y            (rsp_dst_y),
      .rsp_dst_w            (rsp_dst_w),
      .rsp_dst_h            (rsp_dst_h),
      .rsp_measured_width   (rsp_measured_width),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Layout predictor
   // ------------------------------------------------------------------------

   // floor(v * scale / 256), never below one pixel
   function automatic int unsigned scale_px(int unsigned v);
      int unsigned r;
      r = (v * cfg_scale) >> 8;
      return (r < 1) ? 1 : r;
   endfunction

   function automatic int unsigned pen_step(int unsigned a, int unsigned b);
      return (a + b > PEN_LIMIT) ? PEN_LIMIT : a + b;
   endfunction

   function automatic logic [15:0] place_coord(logic signed [15:0] org, int unsigned off);
      int s;
      s = int'(org) + int'(off);
      if (s > DST_MAX) s = DST_MAX;
      if (s < DST_MIN) s = DST_MIN;
      return s[15:0];
   endfunction

   // Handle one decoded code point: newline, or draw and advance
   function automatic void draw_code(logic [10:0] cp);
      logic [7:0]  idx;
      ptl_rsp_type r;
      int unsigned cols, col, row;
      if (cp == {3'b000, CHAR_NEWLINE}) begin
         if (pen_x > widest) widest = pen_x;
         pen_x = 0;
         pen_y = pen_step(pen_y, scale_px(cfg_cell_h));
         return;
      end
      idx = (cp <= 11'd255) ? cp[7:0] : CHAR_QUESTION;
      if (tbl_draw[idx] != 8'd0) begin
         case (cfg_layout)
            LAYOUT_COLUMN: cols = 1;
            LAYOUT_ROW:    cols = 256;
            default:       cols = 16;
         endcase
         col = idx % cols;
         row = idx / cols;
         r = '0;
         r.kind  = KIND_GLYPH;
         r.src_x = col * cfg_cell_w + tbl_left[idx];
         r.src_y = row * cfg_cell_h;
         r.src_w = tbl_draw[idx];
         r.src_h = cfg_cell_h;
         r.dst_x = place_coord(cfg_origin_x, pen_x);
         r.dst_y = place_coord(cfg_origin_y, pen_y);
         r.dst_w = scale_px(tbl_draw[idx]);
         r.dst_h = scale_px(cfg_cell_h);
         item_results.push_back(r);
      end
      pen_x = pen_step(pen_x, scale_px(tbl_adv[idx]));
   endfunction

   // Work out the results of one accepted item and queue them
   function automatic void lay_out_item(text_item_t it);
      logic [7:0]  b;
      ptl_rsp_type s;
      if (it.cmd == CMD_METRICS) begin
         tbl_left[it.glyph_index] = it.glyph_left;
         tbl_draw[it.glyph_index] = it.glyph_draw_width;
         tbl_adv[it.glyph_index]  = it.glyph_advance;
         return;
      end
      b = it.text_byte;
      item_results.delete();
      if (held_valid && (b & UTF_CONT_MASK) == UTF_CONT) begin
         held_valid = 1'b0;
         draw_code({held_lead[4:0], b[5:0]});
      end else begin
         // flush a held lead byte that found no continuation
         if (held_valid) begin
            held_valid = 1'b0;
            draw_code({3'b000, held_lead});
         end
         if ((b & UTF_LEAD_MASK) == UTF_LEAD && !it.end_of_string) begin
            held_lead  = b;
            held_valid = 1'b1;
         end else begin
            draw_code({3'b000, b});
         end
      end
      // close the string: report widest line and clear the pen
      if (it.end_of_string) begin
         s = '0;
         s.kind     = KIND_SUMMARY;
         s.measured = (pen_x > widest) ? pen_x : widest;
         item_results.push_back(s);
         pen_x      = 0;
         pen_y      = 0;
         widest     = 0;
         held_lead  = '0;
         held_valid = 1'b0;
      end
      foreach (item_results[i]) begin
         s = item_results[i];
         s.last = (i == item_results.size() - 1);
         layout_results_due.push_back(s);
      end
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         err_count++;
      end
   endtask

   task automatic check_result();
      ptl_rsp_type want;
      if (layout_results_due.size() == 0) begin
         $error("result item with no expectation waiting");
         err_count++;
         return;
      end
      want = layout_results_due.pop_front();
      check_field("kind", want.kind, rsp_kind);
      check_field("src_x", want.src_x, rsp_src_x);
      check_field("src_y", want.src_y, rsp_src_y);
      check_field("src_w", want.src_w, rsp_src_w);
      check_field("src_h", want.src_h, rsp_src_h);
      check_field("dst_x", want.dst_x, rsp_dst_x);
      check_field("dst_y", want.dst_y, rsp_dst_y);
      check_field("dst_w", want.dst_w, rsp_dst_w);
      check_field("dst_h", want.dst_h, rsp_dst_h);
      check_field("measured_width", want.measured, rsp_measured_width);
      check_field("last", want.last, rsp_last);
   endtask

   // ------------------------------------------------------------------------
   // Monitor: predict accepted items, check results, track registers
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (reset) begin
         req_fire     <= 1'b0;
         pen_x        = 0;
         pen_y        = 0;
         widest       = 0;
         held_lead    = '0;
         held_valid   = 1'b0;
         cfg_cell_w   = CELL_W_RST;
         cfg_cell_h   = CELL_H_RST;
         cfg_layout   = LAYOUT_GRID;
         cfg_origin_x = '0;
         cfg_origin_y = '0;
         cfg_scale    = SCALE_RST;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CELL_W:   cfg_cell_w   = csr_data[7:0];
               CSR_CELL_H:   cfg_cell_h   = csr_data[7:0];
               CSR_LAYOUT:   cfg_layout   = csr_data[1:0];
               CSR_ORIGIN_X: cfg_origin_x = csr_data;
               CSR_ORIGIN_Y: cfg_origin_y = csr_data;
               CSR_SCALE:    cfg_scale    = csr_data[11:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            lay_out_item(req_item);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) check_result();
      end
   end

   // ------------------------------------------------------------------------
   // Driver: present queued items and stall the result side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_items
      int send_gap, recv_gap;
      // receiver stalls heavily first, then the sender idles heavily, then neither
      if (accepted_count < 65) begin
         send_gap = 8;
         recv_gap = 59;
      end else if (accepted_count < 130) begin
         send_gap = 59;
         recv_gap = 8;
      end else begin
         send_gap = 0;
         recv_gap = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_gap);
         // hold the current item until it is taken
         if (!req_valid || req_fire) begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
               req_item  <= items_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic void queue_metrics(logic [7:0] idx, logic [7:0] left,
                                         logic [7:0] dw, logic [7:0] adv);
      text_item_t it;
      it.cmd              = CMD_METRICS;
      it.glyph_index      = idx;
      it.glyph_left       = left;
      it.glyph_draw_width = dw;
      it.glyph_advance    = adv;
      it.text_byte        = $urandom_range(0, 255);
      it.end_of_string    = $urandom_range(0, 1);
      items_to_send.push_back(it);
      glyph_known[idx] = 1'b1;
   endfunction

   function automatic void queue_random_metrics(logic [7:0] idx);
      logic [7:0] dw;
      dw = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      queue_metrics(idx, $urandom_range(0, 255), dw, $urandom_range(1, 250));
   endfunction

   // Queue one text byte, writing first any glyph entry it would read unwritten
   function automatic void queue_byte(logic [7:0] b, bit eos);
      text_item_t  it;
      logic [10:0] cp;
      logic [7:0]  reads[$];
      if (gen_held && (b & UTF_CONT_MASK) == UTF_CONT) begin
         cp = {gen_lead[4:0], b[5:0]};
         gen_held = 1'b0;
         if (cp != {3'b000, CHAR_NEWLINE})
            reads.push_back((cp <= 11'd255) ? cp[7:0] : CHAR_QUESTION);
      end else begin
         if (gen_held) begin
            reads.push_back(gen_lead);
            gen_held = 1'b0;
         end
         if ((b & UTF_LEAD_MASK) == UTF_LEAD && !eos) begin
            gen_held = 1'b1;
            gen_lead = b;
         end else if (b != CHAR_NEWLINE) begin
            reads.push_back(b);
         end
      end
      foreach (reads[i]) begin
         if (!glyph_known[reads[i]]) queue_random_metrics(reads[i]);
      end
      it.cmd              = CMD_TEXT;
      it.glyph_index      = $urandom_range(0, 255);
      it.glyph_left       = $urandom_range(0, 255);
      it.glyph_draw_width = $urandom_range(0, 255);
      it.glyph_advance    = $urandom_range(0, 255);
      it.text_byte        = b;
      it.end_of_string    = eos;
      items_to_send.push_back(it);
   endfunction

   // One string of mostly well-formed text with some noise mixed in
   function automatic void queue_string(int unsigned len);
      logic [7:0] bytes[$];
      int unsigned pick;
      while (bytes.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            bytes.push_back($urandom_range(8'h20, 8'h7E));
         end else if (pick < 57) begin
            bytes.push_back(CHAR_NEWLINE);
         end else if (pick < 77) begin
            bytes.push_back($urandom_range(8'hC2, 8'hDF));
            bytes.push_back(UTF_CONT | 8'($urandom_range(0, 63)));
         end else if (pick < 82) begin
            bytes.push_back(UTF_LEAD);
            bytes.push_back(UTF_CONT | CHAR_NEWLINE);
         end else if (pick < 90) begin
            bytes.push_back($urandom_range(0, 255));
         end else begin
            bytes.push_back($urandom_range(8'hC0, 8'hDF));
         end
      end
      foreach (bytes[i]) begin
         if ($urandom_range(0, 9) == 0) queue_random_metrics($urandom_range(0, 255));
         queue_byte(bytes[i], i == bytes.size() - 1);
      end
   endfunction

   function automatic void queue_random_text(int unsigned n_items);
      int unsigned target;
      target = items_to_send.size() + n_items;
      while (items_to_send.size() < target) queue_string($urandom_range(1, 8));
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(logic [7:0] cell_w, logic [7:0] cell_h, logic [1:0] layout,
                             logic [15:0] org_x, logic [15:0] org_y, logic [11:0] scale);
      write_csr(CSR_CELL_W, cell_w);
      write_csr(CSR_CELL_H, cell_h);
      write_csr(CSR_LAYOUT, layout);
      write_csr(CSR_ORIGIN_X, org_x);
      write_csr(CSR_ORIGIN_Y, org_y);
      write_csr(CSR_SCALE, scale);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every queued item to go in and every result to come out
   task automatic settle(int pad);
      do @(negedge clock);
      while (items_to_send.size() != 0 || req_valid || layout_results_due.size() != 0);
      repeat (pad) @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: decode corner cases at reset settings
      queue_metrics(8'h41, 8'd2, 8'd9, 8'd11);
      queue_metrics(8'h00, 8'h00, 8'h00, 8'd1);
      queue_metrics(8'hFF, 8'hFF, 8'hFF, 8'd250);
      queue_metrics(CHAR_QUESTION, 8'd1, 8'd7, 8'd8);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h00, 1'b0);                  // blank glyph, pen still advances
      queue_byte(8'hFF, 1'b0);
      queue_byte(CHAR_NEWLINE, 1'b0);
      queue_byte(8'hC3, 1'b0);                  // pair decoding to a Latin-1 glyph
      queue_byte(8'hA9, 1'b0);
      queue_byte(8'hD0, 1'b0);                  // pair above 255 drawn as question mark
      queue_byte(8'h90, 1'b0);
      queue_byte(UTF_LEAD, 1'b0);               // overlong pair acting as newline
      queue_byte(UTF_CONT | CHAR_NEWLINE, 1'b0);
      queue_byte(8'hC5, 1'b0);                  // held lead drawn, then a plain byte
      queue_byte(8'h41, 1'b0);
      queue_byte(8'hC3, 1'b0);                  // metrics write inside a pair
      queue_metrics(8'hE9, 8'd5, 8'd3, 8'd4);
      queue_byte(8'hA9, 1'b0);
      queue_byte(8'h80, 1'b0);                  // stray continuation byte
      queue_byte(8'hC5, 1'b0);                  // held lead, then a lead as last byte
      queue_byte(8'hC6, 1'b1);
      queue_byte(8'hDF, 1'b1);                  // lone lead ending a string
      settle(DRAIN_PAD);

      // Extreme settings: drive pen, line offset and destination into saturation
      set_config(8'd255, 8'd255, LAYOUT_ROW, 16'h7FFF, 16'h7FFF, 12'hFFF);
      queue_metrics(WIDE_GLYPH_A, 8'hFF, 8'hFF, 8'd250);
      queue_metrics(WIDE_GLYPH_B, 8'hFF, 8'hFF, 8'd250);
      for (int i = 0; i < 18; i++) queue_byte((i % 2) ? WIDE_GLYPH_B : WIDE_GLYPH_A, 1'b0);
      repeat (17) queue_byte(CHAR_NEWLINE, 1'b0);
      queue_byte(WIDE_GLYPH_A, 1'b1);
      settle(DRAIN_PAD);

      // Smallest cells and scale, most negative origin
      set_config(8'd1, 8'd1, LAYOUT_COLUMN, 16'h8000, 16'h8000, 12'd1);
      queue_random_text(20);
      settle(DRAIN_PAD);

      // Spare layout code and zero scale
      set_config($urandom_range(1, 255), $urandom_range(1, 255), LAYOUT_SPARE,
                 $urandom_range(0, 65535), $urandom_range(0, 65535), 12'd0);
      queue_random_text(20);
      settle(DRAIN_PAD);

      // Random settings
      repeat (5) begin
         set_config($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 2),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(1, 4095));
         queue_random_text(20);
         settle(DRAIN_PAD);
      end

      settle(END_PAD);
      if (err_count == 0 && layout_results_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== proportional_text_layout.f =====
hw/rtl/ptl_pkg.sv
hw/rtl/ptl_glyph_mem.sv
hw/rtl/ptl_decode.sv
hw/rtl/ptl_layout.sv
hw/rtl/ptl_rsp_queue.sv
hw/rtl/proportional_text_layout.sv
hw/rtl/ptl_checker.sv
sim/tb_proportional_text_layout.sv
